/* design/sdlw_pkg.sv */
// Shared types and constants for the signed decimal LCD writer.
`default_nettype none
package sdlw_pkg;

	// Cursor address base, and the character codes
	localparam logic [7:0] ADDR_BASE  = 8'd96;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] MINUS_CHAR = 8'h2D;
	localparam int unsigned FONT_BIT  = 7;

	// A 16-bit magnitude has at most five decimal digits
	localparam int unsigned MAX_DIGITS = 5;
	localparam int unsigned DIGIT_IDX_W = 3;

	// Reciprocal of ten: (x * 52429) >> 19 is exact for every 16-bit x
	localparam logic [16:0] RECIP_TEN   = 17'd52429;
	localparam int unsigned RECIP_SHIFT = 19;

	typedef struct packed {
		logic [2:0]         row;
		logic [4:0]         column;
		logic signed [15:0] value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_command;
		logic       last_byte;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_CMD,
		ST_SIGN,
		ST_DIGITS
	} state_t;

endpackage
`default_nettype wire

/* design/sdlw_div10.sv */
// Divide-by-ten unit: quotient by reciprocal multiplication, remainder by shift-add.
`default_nettype none
module sdlw_div10 (
	input  wire logic [15:0] dividend,
	output logic      [15:0] quotient,
	output logic      [3:0]  remainder
);

	logic [32:0] prod;
	logic [15:0] times_ten;

	assign prod      = 33'(dividend) * 33'(sdlw_pkg::RECIP_TEN);
	assign quotient  = 16'(prod >> sdlw_pkg::RECIP_SHIFT);
	assign times_ten = 16'(quotient << 3) + 16'(quotient << 1);
	assign remainder = 4'(dividend - times_ten);

endmodule
`default_nettype wire

/* design/signed_decimal_lcd_writer.sv */
// Top level of the signed decimal LCD writer: sequencer, digit store and output register.
`default_nettype none
// Turns one item (row, column, signed 16-bit value) into a character-LCD byte
// stream: first a cursor address command byte, 96 + row*32 + column wrapped to
// 8 bits, then the value in decimal, most significant character first, with a
// leading '-' for negative values, no leading zeros and a lone '0' for zero.
// Every character has bit 7 set to pick the alternate font, and the final data
// byte carries last_byte. An item runs through a shared divide-by-ten unit,
// one digit per cycle, while the digits collect in a small store; the bytes
// then leave through a single output register, one per beat. The sequencer
// takes no new item until every byte of the last one is in that register.
// item_ready is high only while the sequencer is idle; the last byte of an
// item may still wait in the output register when the next item is taken,
// and the new item's bytes queue behind it.
module signed_decimal_lcd_writer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire sdlw_pkg::in_item_t  item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output sdlw_pkg::out_item_t      result
);

	sdlw_pkg::state_t state_q, state_d;

	logic [7:0]  addr_q;
	logic        neg_q;
	logic [15:0] mag_q;
	logic [3:0]  digit_q [sdlw_pkg::MAX_DIGITS];
	logic [sdlw_pkg::DIGIT_IDX_W-1:0] dig_cnt_q;

	logic                result_valid_q;
	sdlw_pkg::out_item_t result_q;

	logic [15:0] quotient;
	logic [3:0]  remainder;

	logic                accept;
	logic                slot_free;
	logic                load;
	logic                div_step;
	logic                div_done;
	sdlw_pkg::out_item_t load_item;
	logic [3:0]          cur_digit;
	logic [15:0]         in_mag;

	// Shared divide-by-ten unit, reused once per digit
	sdlw_div10 u_div10 (
		.dividend  (mag_q),
		.quotient  (quotient),
		.remainder (remainder)
	);

	assign accept    = item_valid && item_ready;
	assign slot_free = !result_valid_q || result_ready;
	assign div_done  = (quotient == 16'd0) ||
		(dig_cnt_q == sdlw_pkg::DIGIT_IDX_W'(sdlw_pkg::MAX_DIGITS - 1));
	assign cur_digit = digit_q[sdlw_pkg::DIGIT_IDX_W'(dig_cnt_q - 1'b1)];

	// Magnitude in unsigned arithmetic, so the most negative value gives 32768
	assign in_mag = item.value[15] ? 16'(16'd0 - item.value) : item.value;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sdlw_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = sdlw_pkg::ST_DIVIDE;
				end
			end
			sdlw_pkg::ST_DIVIDE: begin
				if (div_done) begin
					state_d = sdlw_pkg::ST_CMD;
				end
			end
			sdlw_pkg::ST_CMD: begin
				if (slot_free) begin
					state_d = neg_q ? sdlw_pkg::ST_SIGN : sdlw_pkg::ST_DIGITS;
				end
			end
			sdlw_pkg::ST_SIGN: begin
				if (slot_free) begin
					state_d = sdlw_pkg::ST_DIGITS;
				end
			end
			sdlw_pkg::ST_DIGITS: begin
				if (slot_free && dig_cnt_q == sdlw_pkg::DIGIT_IDX_W'(1)) begin
					state_d = sdlw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sdlw_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		item_ready = 1'b0;
		div_step   = 1'b0;
		load       = 1'b0;
		load_item  = '0;
		unique case (state_q)
			sdlw_pkg::ST_IDLE: begin
				item_ready = 1'b1;
			end
			sdlw_pkg::ST_DIVIDE: begin
				div_step = 1'b1;
			end
			sdlw_pkg::ST_CMD: begin
				load                 = slot_free;
				load_item.out_byte   = addr_q;
				load_item.is_command = 1'b1;
				load_item.last_byte  = 1'b0;
			end
			sdlw_pkg::ST_SIGN: begin
				load                 = slot_free;
				load_item.out_byte   = sdlw_pkg::MINUS_CHAR |
					8'(1 << sdlw_pkg::FONT_BIT);
				load_item.is_command = 1'b0;
				load_item.last_byte  = 1'b0;
			end
			sdlw_pkg::ST_DIGITS: begin
				load                 = slot_free;
				load_item.out_byte   = sdlw_pkg::DIGIT_ZERO | {4'd0, cur_digit} |
					8'(1 << sdlw_pkg::FONT_BIT);
				load_item.is_command = 1'b0;
				load_item.last_byte  = (dig_cnt_q == sdlw_pkg::DIGIT_IDX_W'(1));
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= sdlw_pkg::ST_IDLE;
			result_valid_q <= 1'b0;
			dig_cnt_q      <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			// Count digits up while dividing, down while sending them
			if (accept) begin
				dig_cnt_q <= '0;
			end else if (div_step) begin
				dig_cnt_q <= dig_cnt_q + 1'b1;
			end else if (load && state_q == sdlw_pkg::ST_DIGITS) begin
				dig_cnt_q <= dig_cnt_q - 1'b1;
			end
		end
	end

	// Payload: hold the item, advance the magnitude, store each digit
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= 8'(sdlw_pkg::ADDR_BASE + {item.row, item.column});
			neg_q  <= item.value[15];
			mag_q  <= in_mag;
		end else if (div_step) begin
			mag_q <= quotient;
		end
		if (div_step) begin
			digit_q[dig_cnt_q] <= remainder;
		end
		if (load) begin
			result_q <= load_item;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTH
	// The command byte never closes an item's run
	a_cmd_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_command |-> !result.last_byte)
		else $error("command byte flagged as last");

	// The digit count never passes the store depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		dig_cnt_q <= sdlw_pkg::DIGIT_IDX_W'(sdlw_pkg::MAX_DIGITS))
		else $error("digit count out of range");

	// Sending digits always has at least one left in the store
	a_digits_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sdlw_pkg::ST_DIGITS |-> dig_cnt_q != '0)
		else $error("digit state with empty store");

	// A taken item starts the divide loop with an empty store
	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> state_q == sdlw_pkg::ST_DIVIDE && dig_cnt_q == '0)
		else $error("accepted item did not start dividing");
`endif

endmodule
`default_nettype wire

/* bench/signed_decimal_lcd_writer_tb.sv */
// Self-checking bench for the signed decimal LCD writer: directed and random items.
`timescale 1ns / 100ps
module signed_decimal_lcd_writer_tb;

	// Generous ceiling: about 120 items, each up to seven beats, each beat
	// possibly behind a sink stall, plus sender gaps and the block's own
	// processing time, with a wide margin on top.
	localparam int CYCLE_LIMIT = 200_000;
	// Drain for a little longer than the longest item takes
	localparam int DRAIN_CYCLES = 24;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                item_valid;
	logic                item_ready;
	sdlw_pkg::in_item_t  item;
	logic                result_valid;
	logic                result_ready;
	sdlw_pkg::out_item_t result;

	// Bytes still owed by the block, oldest first
	sdlw_pkg::out_item_t pending_lcd_bytes[$];
	int        mismatch_count = 0;
	int        cycle_count = 0;
	// Switch idling on either side of the link
	bit        sender_gaps = 1'b0;
	bit        sink_stalls = 1'b0;

	signed_decimal_lcd_writer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	// Queue one expected byte
	function automatic void owe_byte(logic [7:0] code, logic cmd, logic last);
		sdlw_pkg::out_item_t b;
		b.out_byte   = code;
		b.is_command = cmd;
		b.last_byte  = last;
		pending_lcd_bytes.push_back(b);
	endfunction

	// Work out the full byte run for one accepted item: the cursor address,
	// then an optional minus and the digits, most significant first
	function automatic void predict_lcd_bytes(sdlw_pkg::in_item_t it);
		int         magnitude;
		int         digit[5];
		int         ndigits;
		logic [7:0] font;
		logic [7:0] addr;
		font      = 8'(1 << sdlw_pkg::FONT_BIT);
		// An 8-bit sum: rows five to seven wrap round
		addr      = 8'(int'(sdlw_pkg::ADDR_BASE) + int'(it.row) * 32 + int'(it.column));
		// Widen to int first so that -32768 has a clean magnitude
		magnitude = int'(it.value);
		if (magnitude < 0)
			magnitude = -magnitude;
		ndigits = 0;
		do begin
			digit[ndigits] = magnitude % 10;
			magnitude      = magnitude / 10;
			ndigits++;
		end while (magnitude != 0);

		owe_byte(addr, 1'b1, 1'b0);
		// A digit always follows the sign, so the minus is never last
		if (it.value[15])
			owe_byte(sdlw_pkg::MINUS_CHAR | font, 1'b0, 1'b0);
		for (int i = ndigits - 1; i >= 0; i--)
			owe_byte((sdlw_pkg::DIGIT_ZERO + 8'(digit[i])) | font, 1'b0, i == 0);
	endfunction

	// Offer one item and hold it until the block takes it. Called right after
	// a rising edge; valid stays high between items unless a gap is drawn.
	task automatic send_item(logic [2:0] row, logic [4:0] column, logic signed [15:0] value);
		sdlw_pkg::in_item_t beat_item;
		beat_item.row    = row;
		beat_item.column = column;
		beat_item.value  = value;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= beat_item;
		do
			@(posedge clk);
		while (!(item_valid && item_ready));
		predict_lcd_bytes(beat_item);
	endtask

	// Draw a value that favours digit-count boundaries and the extremes
	function automatic logic signed [15:0] random_value();
		int pick;
		int mag;
		int pow;
		pick = $urandom_range(0, 5);
		case (pick)
			0: mag = $urandom_range(0, 12);
			1: begin
				pow = 1;
				repeat ($urandom_range(1, 4)) pow = pow * 10;
				mag = pow + $urandom_range(0, 2) - 1;
			end
			2: mag = 32768 - $urandom_range(0, 2);
			default: return 16'($urandom);
		endcase
		// 32768 is only reachable as a negative number
		if (mag == 32768 || $urandom_range(0, 1) == 1)
			return 16'(-mag);
		return 16'(mag);
	endfunction

	// Rows are nominally 0..4, but out-of-range rows must wrap cleanly
	function automatic logic [2:0] random_row();
		if ($urandom_range(0, 5) == 0)
			return 3'($urandom_range(5, 7));
		return 3'($urandom_range(0, 4));
	endfunction

	// Lone digits, zero and the single-digit negatives
	task automatic test_short_values();
		send_item(3'd0, 5'd0, 16'sd0);
		send_item(3'd0, 5'd1, 16'sd1);
		send_item(3'd1, 5'd2, -16'sd1);
		send_item(3'd2, 5'd3, 16'sd9);
		send_item(3'd3, 5'd4, -16'sd9);
	endtask

	// Every change in digit count for positive values, and some for negative ones
	task automatic test_digit_boundaries();
		send_item(3'd0, 5'd10, 16'sd10);
		send_item(3'd1, 5'd11, 16'sd99);
		send_item(3'd2, 5'd12, 16'sd100);
		send_item(3'd3, 5'd13, 16'sd999);
		send_item(3'd4, 5'd14, 16'sd1000);
		send_item(3'd0, 5'd15, 16'sd9999);
		send_item(3'd1, 5'd16, 16'sd10000);
		send_item(3'd2, 5'd17, -16'sd10);
		send_item(3'd3, 5'd18, -16'sd100);
		send_item(3'd4, 5'd19, -16'sd10000);
	endtask

	// Largest, most negative and next-to-most-negative values
	task automatic test_value_extremes();
		send_item(3'd4, 5'd20, 16'sd32767);
		send_item(3'd0, 5'd21, -16'sd32768);
		send_item(3'd1, 5'd22, -16'sd32767);
	endtask

	// Column and row limits, including rows that wrap the address sum
	task automatic test_address_range();
		send_item(3'd4, 5'd31, 16'sd5);
		send_item(3'd5, 5'd0, 16'sd42);
		send_item(3'd6, 5'd16, -16'sd7);
		send_item(3'd7, 5'd31, 16'sd12345);
	endtask

	task automatic test_random_items(int count);
		repeat (count)
			send_item(random_row(), 5'($urandom_range(0, 31)), random_value());
	endtask

	// Sink side: stall in bursts while enabled, otherwise always ready
	initial begin
		result_ready = 1'b0;
		@(posedge clk);
		forever begin
			@(posedge clk);
			if (sink_stalls && $urandom_range(0, 5) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			result_ready <= 1'b1;
		end
	end

	// Compare every accepted beat, field by field, with the oldest byte owed
	always @(posedge clk) begin : check_beat
		sdlw_pkg::out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_lcd_bytes.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual byte %h cmd %b last %b",
					$time, result.out_byte, result.is_command, result.last_byte);
				mismatch_count++;
			end else begin
				want = pending_lcd_bytes.pop_front();
				if (result.out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %h, actual %h",
						$time, want.out_byte, result.out_byte);
					mismatch_count++;
				end
				if (result.is_command !== want.is_command) begin
					$display("%0t: is_command expected %b, actual %b",
						$time, want.is_command, result.is_command);
					mismatch_count++;
				end
				if (result.last_byte !== want.last_byte) begin
					$display("%0t: last_byte expected %b, actual %b",
						$time, want.last_byte, result.last_byte);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("signed_decimal_lcd_writer_tb: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part runs without idling
		test_short_values();
		test_digit_boundaries();
		test_value_extremes();
		test_address_range();

		// Bulk of the random items with gaps and stalls on both sides
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
		test_random_items(68);

		// Final stretch back to back, no idling anywhere
		sender_gaps = 1'b0;
		sink_stalls = 1'b0;
		test_random_items(30);
		item_valid <= 1'b0;

		// Drain, then give a stray extra beat the chance to show up
		while (pending_lcd_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("signed_decimal_lcd_writer_tb: PASS");
		else
			$display("signed_decimal_lcd_writer_tb: FAIL");
		$finish;
	end

endmodule
